// File: rtl/jsu_pkg.sv
package jsu_pkg;

	// Job queue between the parser and the result serializer
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Characters the parser looks for
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_N = 8'h6E;
	localparam logic [7:0] CH_LOW_R = 8'h72;
	localparam logic [7:0] CH_LOW_T = 8'h74;
	localparam logic [7:0] CH_LOW_U = 8'h75;

	// Surrogate ranges
	localparam logic [15:0] HI_SUR_MIN = 16'hD800;
	localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
	localparam logic [10:0] PLANE1_HI = 11'h040;

	typedef enum logic [6:0] {
		PH_WAIT = 7'b0000001,
		PH_STR  = 7'b0000010,
		PH_ESC  = 7'b0000100,
		PH_HEX1 = 7'b0001000,
		PH_BSL  = 7'b0010000,
		PH_LOWU = 7'b0100000,
		PH_HEX2 = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_OK   = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_NO_QUOTE = 3'd1,
		ERR_BAD_ESC  = 3'd2,
		ERR_BAD_HEX  = 3'd3,
		ERR_NO_LOW   = 3'd4,
		ERR_BAD_LOW  = 3'd5,
		ERR_LONE_LOW = 3'd6,
		ERR_TEXT_END = 3'd7
	} err_t;

	// One job: a status beat, or one to four decoded bytes
	typedef struct packed {
		kind_t            kind;
		err_t             err;
		logic [1:0]       last_idx;
		logic [3:0][7:0]  bytes;
	} job_t;

endpackage

// File: rtl/jsu_if.sv
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] in_byte;

	modport source (output valid, output opcode, output in_byte, input ready);
	modport sink (input valid, input opcode, input in_byte, output ready);
endinterface

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic       out_last;

	modport source (output valid, output out_kind, output out_byte, output error_code,
		output out_last, input ready);
	modport sink (input valid, input out_kind, input out_byte, input error_code,
		input out_last, output ready);
endinterface

// File: rtl/jsu_front.sv
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	jsu_in_if.sink        in_ch,
	output logic          q_push,
	output jsu_pkg::job_t q_job,
	input  logic          q_full
);
	import jsu_pkg::*;

	phase_t      phase_q, phase_d;
	logic [11:0] acc_q, acc_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [9:0]  high_q, high_d;

	logic        accept;
	logic        job_vld;
	job_t        job;
	logic        fail;
	err_t        fail_code;
	logic [4:0]  dig;
	logic [15:0] cp_lo;
	logic [20:0] pair_cp;

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [4:0] r;
		case (c) inside
			[8'h30:8'h39]: r = {1'b0, c[3:0]};
			[8'h41:8'h46], [8'h61:8'h66]: r = {1'b0, c[3:0] + 4'd9};
			default: r = 5'h10;
		endcase
		return r;
	endfunction

	function automatic job_t byte_job(input logic [7:0] b);
		job_t j;
		j = '0;
		j.kind = KIND_BYTE;
		j.err = ERR_NONE;
		j.bytes[0] = b;
		return j;
	endfunction

	function automatic job_t utf8_job(input logic [20:0] cp);
		job_t j;
		j = '0;
		j.kind = KIND_BYTE;
		j.err = ERR_NONE;
		if (cp <= 21'h7F) begin
			j.bytes[0] = cp[7:0];
			j.last_idx = 2'd0;
		end else if (cp <= 21'h7FF) begin
			j.bytes[0] = {3'b110, cp[10:6]};
			j.bytes[1] = {2'b10, cp[5:0]};
			j.last_idx = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			j.bytes[0] = {4'b1110, cp[15:12]};
			j.bytes[1] = {2'b10, cp[11:6]};
			j.bytes[2] = {2'b10, cp[5:0]};
			j.last_idx = 2'd2;
		end else begin
			j.bytes[0] = {5'b11110, cp[20:18]};
			j.bytes[1] = {2'b10, cp[17:12]};
			j.bytes[2] = {2'b10, cp[11:6]};
			j.bytes[3] = {2'b10, cp[5:0]};
			j.last_idx = 2'd3;
		end
		return j;
	endfunction

	assign in_ch.ready = !q_full;
	assign accept = in_ch.valid && in_ch.ready;
	assign q_push = accept && job_vld;
	assign q_job = job;

	assign dig = nibble_of(in_ch.in_byte);
	assign cp_lo = {acc_q, dig[3:0]};
	assign pair_cp = {11'({1'b0, high_q}) + PLANE1_HI, cp_lo[9:0]};

	always_comb begin
		phase_d = phase_q;
		acc_d = acc_q;
		cnt_d = cnt_q;
		high_d = high_q;
		job_vld = 1'b0;
		job = byte_job(in_ch.in_byte);
		fail = 1'b0;
		fail_code = ERR_NONE;

		case (phase_q)
			PH_STR: begin
				if (in_ch.opcode) begin
					fail = 1'b1;
					fail_code = ERR_TEXT_END;
				end else if (in_ch.in_byte == CH_QUOTE) begin
					phase_d = PH_WAIT;
					job_vld = 1'b1;
					job = '0;
					job.kind = KIND_OK;
					job.err = ERR_NONE;
				end else if (in_ch.in_byte == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else begin
					job_vld = 1'b1;
				end
			end
			PH_ESC: begin
				phase_d = PH_STR;
				if (in_ch.opcode) begin
					fail = 1'b1;
					fail_code = ERR_TEXT_END;
				end else begin
					case (in_ch.in_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: job_vld = 1'b1;
						CH_LOW_B: begin
							job_vld = 1'b1;
							job = byte_job(CH_BS);
						end
						CH_LOW_F: begin
							job_vld = 1'b1;
							job = byte_job(CH_FF);
						end
						CH_LOW_N: begin
							job_vld = 1'b1;
							job = byte_job(CH_LF);
						end
						CH_LOW_R: begin
							job_vld = 1'b1;
							job = byte_job(CH_CR);
						end
						CH_LOW_T: begin
							job_vld = 1'b1;
							job = byte_job(CH_TAB);
						end
						CH_LOW_U: begin
							phase_d = PH_HEX1;
							acc_d = '0;
							cnt_d = '0;
						end
						default: begin
							fail = 1'b1;
							fail_code = ERR_BAD_ESC;
						end
					endcase
				end
			end
			PH_BSL: begin
				if (in_ch.opcode) begin
					fail = 1'b1;
					fail_code = ERR_TEXT_END;
				end else if (in_ch.in_byte != CH_BSLASH) begin
					fail = 1'b1;
					fail_code = ERR_NO_LOW;
				end else begin
					phase_d = PH_LOWU;
				end
			end
			PH_LOWU: begin
				if (in_ch.opcode) begin
					fail = 1'b1;
					fail_code = ERR_TEXT_END;
				end else if (in_ch.in_byte != CH_LOW_U) begin
					fail = 1'b1;
					fail_code = ERR_NO_LOW;
				end else begin
					phase_d = PH_HEX2;
					acc_d = '0;
					cnt_d = '0;
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (in_ch.opcode) begin
					fail = 1'b1;
					fail_code = ERR_TEXT_END;
				end else if (dig[4]) begin
					fail = 1'b1;
					fail_code = ERR_BAD_HEX;
				end else if (cnt_q != 2'd3) begin
					acc_d = {acc_q[7:0], dig[3:0]};
					cnt_d = cnt_q + 2'd1;
				end else begin
					acc_d = '0;
					cnt_d = '0;
					if (phase_q == PH_HEX1) begin
						if (cp_lo inside {[HI_SUR_MIN:HI_SUR_MAX]}) begin
							high_d = cp_lo[9:0];
							phase_d = PH_BSL;
						end else if (cp_lo inside {[LO_SUR_MIN:LO_SUR_MAX]}) begin
							fail = 1'b1;
							fail_code = ERR_LONE_LOW;
						end else begin
							phase_d = PH_STR;
							job_vld = 1'b1;
							job = utf8_job({5'd0, cp_lo});
						end
					end else if (cp_lo inside {[LO_SUR_MIN:LO_SUR_MAX]}) begin
						phase_d = PH_STR;
						job_vld = 1'b1;
						job = utf8_job(pair_cp);
					end else begin
						fail = 1'b1;
						fail_code = ERR_BAD_LOW;
					end
				end
			end
			default: begin
				// between strings: skip white space, then need a quote
				phase_d = PH_WAIT;
				if (in_ch.opcode) begin
					fail = 1'b1;
					fail_code = ERR_NO_QUOTE;
				end else begin
					case (in_ch.in_byte) inside
						CH_SPACE, CH_TAB, CH_LF, CH_CR: phase_d = PH_WAIT;
						CH_QUOTE: phase_d = PH_STR;
						default: begin
							fail = 1'b1;
							fail_code = ERR_NO_QUOTE;
						end
					endcase
				end
			end
		endcase

		if (fail) begin
			phase_d = PH_WAIT;
			acc_d = '0;
			cnt_d = '0;
			job_vld = 1'b1;
			job = '0;
			job.kind = KIND_ERR;
			job.err = fail_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			acc_q <= '0;
			cnt_q <= '0;
			high_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			high_q <= high_d;
		end
	end

endmodule

// File: rtl/jsu_queue.sv
module jsu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output jsu_pkg::job_t pop_job,
	output logic          empty
);
	import jsu_pkg::*;

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/jsu_back.sv
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	output logic          q_pop,
	input  jsu_pkg::job_t q_job,
	jsu_out_if.source     out_ch
);
	import jsu_pkg::*;

	logic       busy_q;
	logic [1:0] idx_q;
	job_t       job_q;
	logic       beat;
	logic       at_last;

	assign beat = out_ch.valid && out_ch.ready;
	assign at_last = (idx_q == job_q.last_idx);
	// load the next job when idle or as the last beat of the current one leaves
	assign q_pop = !q_empty && (!busy_q || (beat && at_last));

	assign out_ch.valid = busy_q;
	assign out_ch.out_kind = job_q.kind;
	assign out_ch.out_byte = job_q.bytes[idx_q];
	assign out_ch.error_code = job_q.err;
	assign out_ch.out_last = at_last;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (beat) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// File: rtl/json_string_unescape_utf8.sv
// Channel  Dir  Payload                                        Handshake
// in_ch    in   opcode[0], in_byte[7:0]                        valid/ready
// out_ch   out  out_kind[1:0], out_byte[7:0], error_code[2:0], valid/ready
//               out_last
//
// Input beats are taken at one per cycle while the job queue has room. Each
// beat is parsed in the cycle it is taken and leaves at most one job.
// A job is one to four output beats; the serializer emits one per cycle while
// out_ch.ready is high, so a \u escape can end in four UTF-8 output beats.
// A result is registered in a queue slot, then in the serializer's job register.
// Reset clears the parser phase, queue pointers and serializer state at once.
// Output stalls back up through the four-job queue to in_ch.ready.
module json_string_unescape_utf8 (
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    in_ch,
	jsu_out_if.source out_ch
);
	import jsu_pkg::*;

	// Parser to queue
	logic q_push;
	job_t q_job_in;
	logic q_full;

	// Queue to serializer
	logic q_pop;
	job_t q_job_out;
	logic q_empty;

	// Front: take one text beat per cycle while the queue has room, track the
	// string phase and the \u digits, and turn each beat into at most one job.
	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_push (q_push),
		.q_job  (q_job_in),
		.q_full (q_full)
	);

	// Short queue: lets the parser run on while the serializer drains
	// a multi-byte UTF-8 sequence or the output stalls.
	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (q_job_out),
		.empty    (q_empty)
	);

	// Back: split each job into output beats, flag the last one.
	jsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_job   (q_job_out),
		.out_ch  (out_ch)
	);

`ifndef NO_ASSERTIONS
	// Status beats always close the results of their input
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.out_kind != KIND_BYTE) |-> out_ch.out_last)
		else $error("status beat without out_last");

	// An error code travels exactly with error beats
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ((out_ch.out_kind == KIND_ERR) == (out_ch.error_code != ERR_NONE)))
		else $error("error code does not match kind");

	// A multi-byte sequence continues without a gap
	a_seq_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.out_last) |=> out_ch.valid)
		else $error("gap inside a multi-byte sequence");
`endif

endmodule
